[sv/pnc_pkg.sv]
// Shared types and constants for the palette nearest-colour search block.
`timescale 1ns / 1ps
package pnc_pkg;

  localparam int COMP_W  = 11;  // signed query component
  localparam int IDX_W8  = 8;   // external index width
  localparam int ENTRY_W = 24;  // packed palette entry
  localparam int SCORE_W = 24;  // holds every reachable score, signed

  localparam logic signed [SCORE_W-1:0] INITIAL_SCORE = 24'sd262144;
  localparam logic signed [COMP_W-1:0]  COMPONENT_MAX = 11'sd255;
  localparam logic signed [11:0]        LINEAR_WEIGHT = 12'sd5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] CFG_FIRST_INDEX = 2'd0;
  localparam logic [1:0] CFG_LAST_INDEX  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;        // write palette entry
    logic init;        // capture query, reset best, point at first entry
    logic issue;       // read next entry into the pipe
    logic compare_en;  // allow best score update
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_empty; // nothing to scan
    logic issue_last;  // address being issued is the last of the range
    logic hit;         // zero score at compare stage
    logic scan_end;    // last entry at compare stage
  } dp_status_t;

endpackage

[sv/pnc_ram.sv]
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module pnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pnc_ctrl.sv]
// Controller state machine: sequences loads and palette scans.
`timescale 1ns / 1ps
module pnc_ctrl import pnc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       mode,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_QUERY) begin
            cmd.init   = 1'b1;
            state_next = status.range_empty ? ST_REPORT : ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue      = 1'b1;
        cmd.compare_en = 1'b1;
        if (status.hit) begin
          state_next = ST_REPORT;
        end else if (status.issue_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.compare_en = 1'b1;
        if (status.hit || status.scan_end) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[sv/pnc_datapath.sv]
// Datapath: palette RAM, scan address, scoring pipe and best-score tracker.
`timescale 1ns / 1ps
module pnc_datapath import pnc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  input  logic [IDX_W8-1:0]        first_index,
  input  logic [IDX_W8-1:0]        last_index,
  input  logic [IDX_W8-1:0]        entry_index,
  input  logic signed [COMP_W-1:0] red,
  input  logic signed [COMP_W-1:0] green,
  input  logic signed [COMP_W-1:0] blue,
  output dp_status_t               status,
  output logic [IDX_W8-1:0]        best_index
);

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W8:0] TOP_INDEX = (IDX_W8 + 1)'(PALETTE_ENTRIES - 1);

  function automatic logic signed [COMP_W-1:0] clamp_top(input logic signed [COMP_W-1:0] c);
    clamp_top = (c > COMPONENT_MAX) ? COMPONENT_MAX : c;
  endfunction

  // d*(d+5), d = query component minus entry component
  function automatic logic signed [SCORE_W-1:0] term(input logic signed [COMP_W-1:0] c,
                                                     input logic [7:0] e);
    logic signed [11:0] d;
    logic signed [11:0] dp;
    d    = {c[COMP_W-1], c} - $signed({4'b0000, e});
    dp   = d + LINEAR_WEIGHT;
    term = SCORE_W'(d) * SCORE_W'(dp);
  endfunction

  logic signed [COMP_W-1:0]  q_red, q_green, q_blue;
  logic [IDX_W8-1:0]         addr;
  logic [IDX_W8-1:0]         stop;
  logic                      v1, v2, last1, last2;
  logic [IDX_W8-1:0]         idx1, idx2;
  logic [ENTRY_W-1:0]        rd_data;
  logic signed [SCORE_W-1:0] prod_r, prod_g, prod_b;
  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W-1:0] best_score;
  logic [IDX_W8-1:0]         best_idx;
  logic                      better;
  logic                      load_we;

  // range end limited to the palette
  assign stop = ({1'b0, last_index} > TOP_INDEX) ? TOP_INDEX[IDX_W8-1:0] : last_index;

  assign load_we = cmd.load && ({1'b0, entry_index} <= TOP_INDEX);

  pnc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (entry_index[ADDR_W-1:0]),
    .wdata ({blue[7:0], green[7:0], red[7:0]}),
    .raddr (addr[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (cmd.init) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      q_red   <= clamp_top(red);
      q_green <= clamp_top(green);
      q_blue  <= clamp_top(blue);
      addr    <= first_index;
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end
    idx1   <= addr;
    last1  <= (addr == stop);
    idx2   <= idx1;
    last2  <= last1;
    prod_r <= term(q_red,   rd_data[7:0]);
    prod_g <= term(q_green, rd_data[15:8]);
    prod_b <= term(q_blue,  rd_data[23:16]);
  end

  assign score  = prod_r + prod_g + prod_b;
  assign better = v2 && (score < best_score);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_score <= INITIAL_SCORE;
      best_idx   <= '0;
    end else if (cmd.compare_en && better) begin
      best_score <= score;
      best_idx   <= idx2;
    end
  end

  assign status.range_empty = (first_index > stop);
  assign status.issue_last  = (addr == stop);
  assign status.hit         = better && (score == '0);
  assign status.scan_end    = v2 && last2;
  assign best_index         = best_idx;

endmodule

[sv/palette_nearest_color_unit.sv]
// Top level of the palette nearest-colour search unit.
//
// Command channel: an item is taken when start is high and busy is low.
// mode = 0 loads palette entry entry_index with the low 8 bits of red,
// green and blue; it gives no result and busy stays low.
// mode = 1 searches entries first_index..last_index (clamped to the
// palette) for the lowest score; components above 255 are clamped first.
// A search gives one result: best_index is valid for exactly one cycle
// while done is high. The receiver cannot stall; done is never held.
// A search that meets a zero score ends early, before the rest of the range
// is scored; an empty range goes straight to the report state. busy stays
// high until the done cycle ends, so no new item is taken before then.
// One palette entry per cycle is scored through a single RAM read port
// feeding one three-multiplier scoring stage.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 = first_index,
// 1 = last_index, others ignored) and cfg_data; cfg_ready is low while busy.
// Reset (rst, synchronous) sets first_index to 1, last_index to 254 and
// returns to idle; palette contents are undefined until loaded.
`timescale 1ns / 1ps
module palette_nearest_color_unit import pnc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [IDX_W8-1:0]        entry_index,
  input  logic signed [COMP_W-1:0] red,
  input  logic signed [COMP_W-1:0] green,
  input  logic signed [COMP_W-1:0] blue,
  output logic                     done,
  output logic [IDX_W8-1:0]        best_index,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [IDX_W8-1:0]        cfg_data
);

  logic [IDX_W8-1:0] first_index;
  logic [IDX_W8-1:0] last_index;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  // range registers only change while no search is running
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_index <= 8'd1;
      last_index  <= 8'd254;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_INDEX: first_index <= cfg_data;
        CFG_LAST_INDEX:  last_index  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pnc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pnc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .first_index (first_index),
    .last_index  (last_index),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .status      (status),
    .best_index  (best_index)
  );

`ifndef NO_ASSERTIONS
  // a load item finishes in its own cycle and never reports
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_LOAD) |=> (!busy && !done))
    else $error("load item left the unit busy or reported a result");

  // a query always occupies the unit
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_QUERY) |=> busy)
    else $error("query item not taken up");

  // result strobe only while busy, and the unit frees straight after
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("unit still busy after reporting");
`endif

endmodule
